// ===== hdl/asum_pkg.sv =====
// Shared types and codes for the array sum accelerator.
`default_nettype none
package asum_pkg;

  localparam int WordW = 32;
  localparam int OpLsb = 12;
  localparam int OpW = 3;

  localparam logic [1:0] CMD_ISSUE = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] KIND_SUM         = 2'd0;
  localparam logic [1:0] KIND_BUSY        = 2'd1;
  localparam logic [1:0] KIND_UNSUPPORTED = 2'd2;
  localparam logic [1:0] KIND_BADARG      = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [WordW-1:0] instruction_word;
    logic [WordW-1:0] base_address;
    logic [WordW-1:0] element_count;
    logic             mem_can_request;
    logic             mem_response_valid;
    logic [WordW-1:0] mem_response_data;
  } step_in_t;

  typedef struct packed {
    logic             mem_request_valid;
    logic [WordW-1:0] mem_request_address;
    logic             mem_response_consume;
    logic             response_pending;
    logic [WordW-1:0] response_value;
    logic [1:0]       response_kind;
    logic             job_busy;
  } step_out_t;

  typedef struct packed {
    logic busy;
    logic pending;
    logic waiting;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/array_sum_accelerator_core.sv =====
// An accepted item passes the input register and then the result register on its way out.
// Throughput: one item per cycle unless m_axis_tready stalls; one job state step per item.
// The result register is reloaded as it is taken, so input and output run concurrently.
// Reset (rst, synchronous, active high) clears both stage valid flags and all job state to zero.
`default_nettype none
module array_sum_accelerator_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // From bit 0: instruction_word[31:0], base_address[63:32], element_count[95:64],
  // mem_can_request[96], mem_response_valid[97], mem_response_data[129:98], zeros.
  input  wire logic [135:0] s_axis_tdata,
  // command[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // From bit 0: mem_request_valid[0], mem_request_address[32:1], mem_response_consume[33],
  // response_pending[34], response_value[66:35], job_busy[67], zeros.
  output logic [71:0]       m_axis_tdata,
  // response_kind[1:0]
  output logic [1:0]        m_axis_tuser
);

  logic                in_valid;
  asum_pkg::step_in_t  in_reg;
  asum_pkg::step_in_t  in_next;
  logic                out_valid;
  asum_pkg::step_out_t out_reg;
  asum_pkg::step_out_t step_res;
  asum_pkg::status_t   status;
  logic                advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  assign in_next = '{
    command:            s_axis_tuser,
    instruction_word:   s_axis_tdata[31:0],
    base_address:       s_axis_tdata[63:32],
    element_count:      s_axis_tdata[95:64],
    mem_can_request:    s_axis_tdata[96],
    mem_response_valid: s_axis_tdata[97],
    mem_response_data:  s_axis_tdata[129:98]
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_reg <= in_next;
    end
  end

  asum_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .step_en  (advance),
    .step_in  (in_reg),
    .step_out (step_res),
    .status   (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_reg.job_busy, out_reg.response_value,
                          out_reg.response_pending, out_reg.mem_response_consume,
                          out_reg.mem_request_address, out_reg.mem_request_valid};
  assign m_axis_tuser  = out_reg.response_kind;

`ifndef SYNTHESIS
  // A single step never both issues a request and takes a response.
  a_req_xor_consume: assert property (@(posedge clk) disable iff (rst)
    advance |-> !(step_res.mem_request_valid && step_res.mem_response_consume))
    else $error("request and consume in the same step");

  // Taking a memory word leaves the job ready to request the next one.
  a_consume_clears_wait: assert property (@(posedge clk) disable iff (rst)
    advance && step_res.mem_response_consume |=> !status.waiting)
    else $error("still waiting after a consumed word");

  // Only a read reports a nonzero kind.
  a_kind_on_read: assert property (@(posedge clk) disable iff (rst)
    advance && (in_reg.command != asum_pkg::CMD_READ)
      |-> step_res.response_kind == asum_pkg::KIND_SUM)
    else $error("kind reported outside a read");

  // A request only comes from an active job.
  a_req_when_busy: assert property (@(posedge clk) disable iff (rst)
    advance && step_res.mem_request_valid |-> status.busy && step_res.job_busy)
    else $error("memory request without an active job");
`endif

endmodule
`default_nettype wire

// ===== hdl/asum_engine.sv =====
// Job state and the one-step sequencer of the array sum accelerator.
`default_nettype none
module asum_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step_en,
  input  wire asum_pkg::step_in_t step_in,
  output asum_pkg::step_out_t     step_out,
  output asum_pkg::status_t       status
);

  logic                       busy_flag, busy_flag_next;
  logic                       response_flag, response_flag_next;
  logic                       waiting, waiting_next;
  logic [asum_pkg::WordW-1:0] job_base, job_base_next;
  logic [asum_pkg::WordW-1:0] job_length, job_length_next;
  logic [asum_pkg::WordW-1:0] word_index, word_index_next;
  logic [asum_pkg::WordW-1:0] running_sum, running_sum_next;
  logic [asum_pkg::WordW-1:0] stored_response, stored_response_next;
  logic [1:0]                 stored_kind, stored_kind_next;
  logic [asum_pkg::OpW-1:0]   op;

  assign op = step_in.instruction_word[asum_pkg::OpLsb +: asum_pkg::OpW];

  always_comb begin
    busy_flag_next       = busy_flag;
    response_flag_next   = response_flag;
    waiting_next         = waiting;
    job_base_next        = job_base;
    job_length_next      = job_length;
    word_index_next      = word_index;
    running_sum_next     = running_sum;
    stored_response_next = stored_response;
    stored_kind_next     = stored_kind;
    step_out             = '0;

    unique case (step_in.command)
      asum_pkg::CMD_ISSUE: begin
        // A rejected command posts an error kind, overwriting any response.
        if (busy_flag || response_flag) begin
          stored_response_next = '0;
          stored_kind_next     = asum_pkg::KIND_BUSY;
          response_flag_next   = 1'b1;
        end else if (op != '0) begin
          stored_response_next = '0;
          stored_kind_next     = asum_pkg::KIND_UNSUPPORTED;
          response_flag_next   = 1'b1;
        end else if (step_in.base_address[1:0] != 2'b00) begin
          stored_response_next = '0;
          stored_kind_next     = asum_pkg::KIND_BADARG;
          response_flag_next   = 1'b1;
        end else begin
          job_base_next    = step_in.base_address;
          job_length_next  = step_in.element_count;
          word_index_next  = '0;
          running_sum_next = '0;
          waiting_next     = 1'b0;
          busy_flag_next   = 1'b1;
        end
      end
      asum_pkg::CMD_TICK: begin
        if (busy_flag && !response_flag) begin
          if (word_index == job_length) begin
            stored_response_next = running_sum;
            stored_kind_next     = asum_pkg::KIND_SUM;
            response_flag_next   = 1'b1;
            busy_flag_next       = 1'b0;
            waiting_next         = 1'b0;
          end else if (!waiting) begin
            if (step_in.mem_can_request) begin
              step_out.mem_request_valid   = 1'b1;
              step_out.mem_request_address = job_base + {word_index[asum_pkg::WordW-3:0], 2'b00};
              waiting_next                 = 1'b1;
            end
          end else if (step_in.mem_response_valid) begin
            running_sum_next              = running_sum + step_in.mem_response_data;
            step_out.mem_response_consume = 1'b1;
            word_index_next               = word_index + 1'b1;
            waiting_next                  = 1'b0;
          end
        end
      end
      asum_pkg::CMD_READ: begin
        step_out.response_value = stored_response;
        step_out.response_kind  = stored_kind;
        response_flag_next      = 1'b0;
      end
      default: begin
      end
    endcase

    step_out.response_pending = response_flag_next;
    step_out.job_busy         = busy_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_flag       <= 1'b0;
      response_flag   <= 1'b0;
      waiting         <= 1'b0;
      job_base        <= '0;
      job_length      <= '0;
      word_index      <= '0;
      running_sum     <= '0;
      stored_response <= '0;
      stored_kind     <= asum_pkg::KIND_SUM;
    end else if (step_en) begin
      busy_flag       <= busy_flag_next;
      response_flag   <= response_flag_next;
      waiting         <= waiting_next;
      job_base        <= job_base_next;
      job_length      <= job_length_next;
      word_index      <= word_index_next;
      running_sum     <= running_sum_next;
      stored_response <= stored_response_next;
      stored_kind     <= stored_kind_next;
    end
  end

  assign status = '{busy: busy_flag, pending: response_flag, waiting: waiting};

endmodule
`default_nettype wire
